>>> sv/vlf_pkg.sv
// Shared types and constants for the Van Leer upwind face flux block.
package vlf_pkg;

   localparam int FracBits  = 16;
   localparam int DataWidth = 32;
   localparam int DiffWidth = 34;
   localparam int MagWidth  = 33;
   localparam int HWidth    = FracBits + 1;
   localparam int DivSteps  = FracBits + 1;
   localparam int QueueDepth = 2;

   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   localparam logic [1:0] CsrDtOverDx = 2'd0;
   localparam logic [1:0] CsrDtOverDy = 2'd1;
   localparam logic [1:0] CsrDtOverDz = 2'd2;

   localparam logic [31:0] ScaleReset = 32'd1 << FracBits;

   typedef struct packed {
      logic signed [31:0] velocity;
      logic signed [31:0] conc_lower;
      logic signed [31:0] conc_here;
      logic signed [31:0] conc_upper;
      logic signed [31:0] conc_upper2;
      logic [1:0]         axis;
   } req_type;

   typedef struct packed {
      logic signed [31:0] face_value;
      logic signed [31:0] face_flux;
   } rsp_type;

   // Classified face handed from the front end to the back end.
   typedef struct packed {
      logic                        up;
      logic                        limit;
      logic [MagWidth-1:0]         num_mag;
      logic [MagWidth:0]           sum_mag;
      logic signed [DiffWidth-1:0] diff;
      logic signed [31:0]          base;
      logic [31:0]                 vel_mag_lo;
      logic                        vel_mag_hi;
      logic                        vel_neg;
      logic [31:0]                 scale;
   } face_type;

endpackage

>>> sv/vlf_front.sv
// Front end: accept a face, pick the upwind side and form the ratio terms.
module vlf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vlf_pkg::req_type  req_data,
   input  logic [31:0]       scale_x,
   input  logic [31:0]       scale_y,
   input  logic [31:0]       scale_z,
   output logic              face_valid,
   input  logic              face_ready,
   output vlf_pkg::face_type face_data
);
   import vlf_pkg::*;

   face_type q_ff [QueueDepth];
   face_type q_in;
   logic     wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic     push, pop;
   logic signed [DiffWidth-1:0] num, den, d;
   logic [MagWidth-1:0] nm, dm;
   logic [32:0] vm;

   assign req_ready  = (count_ff != 2'(QueueDepth));
   assign face_valid = (count_ff != 2'd0);
   assign face_data  = q_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop  = face_valid && face_ready;

   always_comb begin
      d   = DiffWidth'(req_data.conc_upper) - DiffWidth'(req_data.conc_here);
      den = d + DiffWidth'(1);
      q_in.up = (req_data.velocity > 0);
      if (q_in.up) begin
         num = DiffWidth'(req_data.conc_here) - DiffWidth'(req_data.conc_lower)
               + DiffWidth'(1);
      end else begin
         num = DiffWidth'(req_data.conc_upper2) - DiffWidth'(req_data.conc_upper)
               + DiffWidth'(1);
      end
      nm = num[DiffWidth-1] ? MagWidth'(-num) : MagWidth'(num);
      dm = den[DiffWidth-1] ? MagWidth'(-den) : MagWidth'(den);
      q_in.limit = (num != '0) && (den != '0) && (num[DiffWidth-1] == den[DiffWidth-1]);
      q_in.num_mag = nm;
      q_in.sum_mag = {1'b0, nm} + {1'b0, dm};
      q_in.diff = d;
      q_in.base = q_in.up ? req_data.conc_here : req_data.conc_upper;
      vm = req_data.velocity[31] ? 33'(-34'(req_data.velocity))
                                 : 33'(req_data.velocity);
      q_in.vel_mag_lo = vm[31:0];
      q_in.vel_mag_hi = vm[32];
      q_in.vel_neg = req_data.velocity[31];
      unique case (req_data.axis)
         AxisX:   q_in.scale = scale_x;
         AxisY:   q_in.scale = scale_y;
         AxisZ:   q_in.scale = scale_z;
         default: q_in.scale = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= q_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

>>> sv/vlf_back.sv
// Back end: pipelined divide, limiter blend and flux product with saturation.
module vlf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              face_valid,
   output logic              face_ready,
   input  vlf_pkg::face_type face_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vlf_pkg::rsp_type  rsp_data
);
   import vlf_pkg::*;

   // Stage count: input reg, DivSteps divide stages, blend, face round, mult1, mult2.
   localparam int Post = 5;
   localparam int Lat = DivSteps + Post;

   logic [Lat-1:0] v_ff;
   logic           adv;

   // Divider pipeline: restoring, one quotient bit per stage.
   face_type            f_ff   [DivSteps+1];
   logic [MagWidth+FracBits:0] rem_ff [DivSteps+1];
   logic [HWidth-1:0]   q_ff   [DivSteps+1];

   // Output register stage.
   rsp_type out_ff;
   logic    out_v_ff;
   logic    full_ff;

   assign adv = !out_v_ff || rsp_ready || !v_ff[Lat-1];
   assign face_ready = adv;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // Holding for the dividend: num << FracBits, shifted out MSB first.
   logic [MagWidth+FracBits-1:0] dvd_ff [DivSteps+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff[0]   <= face_data;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         dvd_ff[0] <= {face_data.num_mag, FracBits'(0)};
      end
   end

   // Quotient fits in HWidth bits, so the upper dividend bits yield zero
   // quotient; fold them into the starting remainder.
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [MagWidth+FracBits:0] trial;
      logic [MagWidth+FracBits:0] pre;
      always_comb begin
         if (k == 0) begin
            pre = {1'b0, dvd_ff[k]} >> (DivSteps - 1);
         end else begin
            pre = {rem_ff[k][MagWidth+FracBits-1:0],
                   dvd_ff[k][MagWidth+FracBits-1]};
         end
         trial = pre - (MagWidth+FracBits+1)'(f_ff[k].sum_mag);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            f_ff[k+1]   <= f_ff[k];
            dvd_ff[k+1] <= (k == 0) ? (dvd_ff[k] << (MagWidth + FracBits - DivSteps + 1))
                                    : (dvd_ff[k] << 1);
            if (!trial[MagWidth+FracBits]) begin
               rem_ff[k+1] <= trial;
               q_ff[k+1]   <= {q_ff[k][HWidth-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= pre;
               q_ff[k+1]   <= {q_ff[k][HWidth-2:0], 1'b0};
            end
         end
      end
   end

   // Blend: t = round(|d|*h), face = base +/- t, saturate.
   logic [MagWidth-1:0] dm;
   logic [HWidth-1:0]   h;
   logic [MagWidth+HWidth-1:0] prod_ff;
   face_type b_ff;
   always_comb begin
      face_type f;
      f  = f_ff[DivSteps];
      dm = f.diff[DiffWidth-1] ? MagWidth'(-f.diff) : MagWidth'(f.diff);
      h  = f.limit ? q_ff[DivSteps] : '0;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= (MagWidth+HWidth)'(dm) * (MagWidth+HWidth)'(h);
         b_ff    <= f_ff[DivSteps];
      end
   end

   logic signed [31:0] face_ff;
   face_type c_ff;
   always_ff @(posedge clock) begin
      logic [MagWidth+HWidth-1:0] tm;
      logic signed [DiffWidth+1:0] t, s;
      tm = (prod_ff + (MagWidth+HWidth)'(1 << (FracBits-1))) >> FracBits;
      t  = b_ff.diff[DiffWidth-1] ? -(DiffWidth+2)'(tm) : (DiffWidth+2)'(tm);
      s  = b_ff.up ? (DiffWidth+2)'(b_ff.base) + t : (DiffWidth+2)'(b_ff.base) - t;
      if (adv) begin
         c_ff <= b_ff;
         if (s > (DiffWidth+2)'(64'sd2147483647))       face_ff <= 32'sh7fffffff;
         else if (s < -(DiffWidth+2)'(64'sd2147483648)) face_ff <= 32'sh80000000;
         else                                           face_ff <= s[31:0];
      end
   end

   // |u|*|face| (33x33), registered, then times scale in two halves.
   logic [64:0] p_ff;
   logic signed [31:0] face2_ff;
   face_type d_ff;
   always_ff @(posedge clock) begin
      logic [32:0] fm;
      fm = face_ff[31] ? 33'(-33'(face_ff)) : 33'(face_ff);
      if (adv) begin
         p_ff     <= {c_ff.vel_mag_hi, c_ff.vel_mag_lo} * fm;
         face2_ff <= face_ff;
         d_ff     <= c_ff;
      end
   end

   logic [63:0] plo_ff;
   logic [64:0] phi_ff;
   logic signed [31:0] face3_ff;
   face_type e_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff   <= 64'(p_ff[31:0]) * 64'(d_ff.scale);
         phi_ff   <= 65'(p_ff[64:32]) * 65'(d_ff.scale);
         face3_ff <= face2_ff;
         e_ff     <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [97:0] full;
      logic [97:0] rnd;
      logic [65:0] mag;
      logic        neg;
      full = 98'(plo_ff) + (98'(phi_ff) << 32);
      rnd  = full + (98'(1) << (2*FracBits-1));
      mag  = 66'(rnd >> (2*FracBits));
      neg  = (e_ff.vel_neg != face3_ff[31]) && (mag != '0);
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         // Hold a stalled beat while a bubble moves up behind it.
         out_v_ff <= v_ff[Lat-1] || (out_v_ff && !rsp_ready);
      end
      if (adv && v_ff[Lat-1]) begin
         out_ff.face_value <= face3_ff;
         if (neg) out_ff.face_flux <= (mag > 66'd2147483648) ? 32'sh80000000
                                                             : -mag[31:0];
         else     out_ff.face_flux <= (mag > 66'd2147483647) ? 32'sh7fffffff
                                                             : mag[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[Lat-2:0], face_valid};
   end

endmodule

>>> sv/van_leer_upwind_face_flux_top.sv
// Top level of the Van Leer upwind face flux block.
//
//  channel | direction | payload           | handshake
//  req_    | in        | vlf_pkg::req_type | req_valid / req_ready
//  rsp_    | out       | vlf_pkg::rsp_type | rsp_valid / rsp_ready
//  csr_    | in        | index, 32b data   | csr_valid / csr_ready
//
// One face per cycle sustained while rsp_ready stays high. From the req beat to
// rsp_valid: front queue, divider input register, 17 divide stages, blend product,
// face rounding, two multiply stages and the flux rounding stage.
// Reset is synchronous: queue and pipeline empty, scales at 1.0.
// A held rsp beat under a low rsp_ready freezes the back pipeline once a
// valid face reaches its last stage; bubbles still close up behind it, and
// the two-entry queue absorbs the front while the stall ripples to req_ready.
module van_leer_upwind_face_flux_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vlf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vlf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import vlf_pkg::*;

   logic [31:0] dx_ff, dy_ff, dz_ff;
   logic        face_valid, face_ready;
   face_type    face_data;

   // Scale registers: always ready, drop writes beyond the list.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dx_ff <= ScaleReset;
         dy_ff <= ScaleReset;
         dz_ff <= ScaleReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrDtOverDx: dx_ff <= csr_data;
            CsrDtOverDy: dy_ff <= csr_data;
            CsrDtOverDz: dz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   vlf_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .scale_x(dx_ff), .scale_y(dy_ff), .scale_z(dz_ff),
      .face_valid, .face_ready, .face_data
   );

   vlf_back u_back (
      .clock, .reset, .face_valid, .face_ready, .face_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

>>> sv/vlf_checker.sv
// Port-level checker for the face flux block, bound to the top level.
module vlf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vlf_pkg::rsp_type rsp_data,
   input logic             csr_ready
);
   import vlf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port stalled");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      $past(!rsp_valid) && !rsp_valid && $past(!req_valid) |-> req_ready)
      else $error("req stalled with empty output");

endmodule

bind van_leer_upwind_face_flux_top vlf_checker u_vlf_checker (
   .clock, .reset, .req_valid, .req_ready,
   .rsp_valid, .rsp_ready, .rsp_data, .csr_ready
);
